// ----- hw/rtl/mcls_pkg.sv -----
// Package for the masked compare-and-swap lock store.
// Holds the sizes, the operation codes, the controller states and the shared structs.
// The controller, the datapath and the top level import it; it depends on nothing.
package mcls_pkg;

    localparam int LOCK_BYTES = 1024;
    localparam int WORD_BYTES = 8;
    localparam int DATA_W     = 64;
    localparam int IDX_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int OFS_W      = 3;
    localparam int ROW_W      = IDX_W - OFS_W;
    localparam int PAIRS      = LOCK_BYTES / (2 * WORD_BYTES);
    localparam int PAIR_W     = $clog2(PAIRS);

    localparam logic [1:0] OP_CAS   = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [IDX_W-1:0]  byte_index;
        logic [DATA_W-1:0] compare_value;
        logic [DATA_W-1:0] swap_value;
        logic [DATA_W-1:0] bit_mask;
    } req_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] prior_value;
        logic              success;
        logic              range_error;
    } rsp_word_t;

    typedef struct packed {
        logic              accept;
        logic              finish;
        logic              sweep;
        logic              sweep_full;
        logic [PAIR_W-1:0] pos;
    } ctrl_t;

    typedef struct packed {
        logic [PAIR_W-1:0]     even_addr;
        logic [PAIR_W-1:0]     odd_addr;
        logic [WORD_BYTES-1:0] even_we;
        logic [WORD_BYTES-1:0] odd_we;
        logic                  re;
        logic [DATA_W-1:0]     even_wdata;
        logic [DATA_W-1:0]     odd_wdata;
    } mem_req_t;

endpackage

// ----- hw/rtl/mcls_ram.sv -----
// Generic single-port RAM with byte write enables and a registered read.
// Depends on nothing; the lock store instantiates it for the even and odd rows.
module mcls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic [WIDTH/8-1:0]       we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < WIDTH / 8; b++)
        begin
            if (we[b])
            begin
                mem_reg[addr][b*8 +: 8] <= wdata[b*8 +: 8];
            end
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/mcls_ctrl.sv -----
// Controller of the lock store: state machine, clearing sweep counter and result valid.
// Depends on mcls_pkg.
module mcls_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic [1:0]     req_op,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mcls_pkg::ctrl_t ctrl
);
    import mcls_pkg::*;

    state_t            state_reg, state_next;
    logic [PAIR_W-1:0] pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              finish;
    logic              sweep;
    logic              pos_last;

    assign pos_last = (pos_reg == PAIR_W'(PAIRS - 1));
    assign sweep    = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
    assign accept   = req_valid && (state_reg == ST_IDLE);
    assign finish   = (state_reg == ST_EXEC) && (!out_valid_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (pos_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = (req_op == OP_CLEAR) ? ST_CLEAR : ST_EXEC;
            end
            ST_CLEAR:
            begin
                if (pos_last)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (finish)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (sweep)
            pos_next = pos_last ? '0 : pos_reg + PAIR_W'(1);
        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        req_ready       = (state_reg == ST_IDLE);
        rsp_valid       = out_valid_reg;
        ctrl.accept     = accept;
        ctrl.finish     = finish;
        ctrl.sweep      = sweep;
        ctrl.sweep_full = (state_reg == ST_INIT);
        ctrl.pos        = pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A read-modify-write request always spends its next cycle in execution.
    a_rmw_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_op != OP_CLEAR) |=> state_reg == ST_EXEC)
        else $error("request did not enter execution");

    // A new result word appears only after an execution cycle.
    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result word without execution");

    // The sweep counter is back at zero whenever the block waits for a request.
    a_pos_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> pos_reg == '0)
        else $error("sweep position left nonzero");

endmodule

// ----- hw/rtl/mcls_datapath.sv -----
// Datapath of the lock store: request register, window extract and merge,
// memory port steering and the result word register.
// Depends on mcls_pkg.
module mcls_datapath (
    input  logic                          clk,
    input  mcls_pkg::ctrl_t               ctrl,
    input  mcls_pkg::req_word_t           req_word,
    input  logic [mcls_pkg::SIZE_W-1:0]   size_eff,
    input  logic [mcls_pkg::DATA_W-1:0]   even_rdata,
    input  logic [mcls_pkg::DATA_W-1:0]   odd_rdata,
    output mcls_pkg::mem_req_t            mem_req,
    output mcls_pkg::rsp_word_t           rsp_word
);
    import mcls_pkg::*;

    req_word_t           req_reg;
    rsp_word_t           rsp_reg, rsp_next;

    logic [ROW_W-1:0]    in_row;
    logic [ROW_W:0]      in_row_inc;
    logic [ROW_W-1:0]    row;
    logic [ROW_W:0]      row_inc;
    logic [OFS_W-1:0]    ofs;
    logic [5:0]          shamt;
    logic [DATA_W-1:0]   lo_rd, hi_rd;
    logic [2*DATA_W-1:0] pair, pair_new, lane_mask;
    logic [DATA_W-1:0]   cur_word, new_word;
    logic                in_range, is_rmw, match, do_write;

    assign in_row     = req_word.byte_index[IDX_W-1:OFS_W];
    assign in_row_inc = {1'b0, in_row} + (ROW_W+1)'(1);
    assign row        = req_reg.byte_index[IDX_W-1:OFS_W];
    assign row_inc    = {1'b0, row} + (ROW_W+1)'(1);
    assign ofs        = req_reg.byte_index[OFS_W-1:0];
    assign shamt      = {ofs, 3'b000};

    // The window spans the row holding its first byte and the row after it.
    assign lo_rd     = row[0] ? odd_rdata : even_rdata;
    assign hi_rd     = row[0] ? even_rdata : odd_rdata;
    assign pair      = {hi_rd, lo_rd};
    assign cur_word  = DATA_W'(pair >> shamt);
    assign new_word  = (cur_word & ~req_reg.bit_mask) | (req_reg.swap_value & req_reg.bit_mask);
    assign lane_mask = {{DATA_W{1'b0}}, {DATA_W{1'b1}}} << shamt;
    assign pair_new  = (pair & ~lane_mask) | ({{DATA_W{1'b0}}, new_word} << shamt);

    assign in_range = ({1'b0, req_reg.byte_index} + SIZE_W'(WORD_BYTES)) <= size_eff;
    assign is_rmw   = (req_reg.operation == OP_CAS) || (req_reg.operation == OP_WRITE);
    assign match    = ((req_reg.compare_value ^ cur_word) & req_reg.bit_mask) == '0;
    assign do_write = is_rmw && in_range && ((req_reg.operation == OP_WRITE) || match);

    always_comb
    begin
        rsp_next = '0;
        if (req_reg.operation == OP_CLEAR)
        begin
            rsp_next.success = 1'b1;
        end
        else if (is_rmw && !in_range)
        begin
            rsp_next.range_error = 1'b1;
        end
        else if (is_rmw)
        begin
            rsp_next.prior_value = cur_word;
            rsp_next.success     = do_write;
        end
    end

    always_comb
    begin
        logic [IDX_W-1:0]      even_byte;
        logic [IDX_W-1:0]      odd_byte;
        logic [WORD_BYTES-1:0] lo_we;
        logic [WORD_BYTES-1:0] hi_we;

        mem_req   = '0;
        even_byte = '0;
        odd_byte  = '0;
        lo_we     = '0;
        hi_we     = '0;
        if (ctrl.sweep)
        begin
            mem_req.even_addr = ctrl.pos;
            mem_req.odd_addr  = ctrl.pos;
            for (int j = 0; j < WORD_BYTES; j++)
            begin
                even_byte = {ctrl.pos, 1'b0, OFS_W'(j)};
                odd_byte  = {ctrl.pos, 1'b1, OFS_W'(j)};
                mem_req.even_we[j] = ctrl.sweep_full || ({1'b0, even_byte} < size_eff);
                mem_req.odd_we[j]  = ctrl.sweep_full || ({1'b0, odd_byte} < size_eff);
            end
        end
        else if (ctrl.accept)
        begin
            mem_req.even_addr = in_row_inc[PAIR_W:1];
            mem_req.odd_addr  = in_row[ROW_W-1:1];
            mem_req.re        = 1'b1;
        end
        else
        begin
            mem_req.even_addr = row_inc[PAIR_W:1];
            mem_req.odd_addr  = row[ROW_W-1:1];
            if (ctrl.finish && do_write)
            begin
                lo_we = '1;
                hi_we = (ofs != '0) ? '1 : '0;
            end
            mem_req.even_we    = row[0] ? hi_we : lo_we;
            mem_req.odd_we     = row[0] ? lo_we : hi_we;
            mem_req.even_wdata = row[0] ? pair_new[2*DATA_W-1:DATA_W] : pair_new[DATA_W-1:0];
            mem_req.odd_wdata  = row[0] ? pair_new[DATA_W-1:0] : pair_new[2*DATA_W-1:DATA_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
            req_reg <= req_word;
        if (ctrl.finish)
            rsp_reg <= rsp_next;
    end

    assign rsp_word = rsp_reg;

endmodule

// ----- hw/rtl/masked_cas_lock_store_top.sv -----
// Top level of the masked compare-and-swap lock store.
// Depends on mcls_pkg, mcls_ctrl, mcls_datapath and mcls_ram.
//
// The lock store holds 1024 lock bytes and serves 64-bit masked atomics on any
// byte-aligned 8-byte window, little-endian. Each request word carries an
// operation (masked compare-and-swap, masked write or clear), a byte index,
// a compare value, a swap value and a bit mask; each request returns exactly
// one response word with the original window value, a success flag and a
// range error flag. A window that reaches past the bytes in use (register
// bytes_in_use, saturated at 1024) changes nothing and reports a range error.
// The bytes live in two single-port RAMs of 64 rows of 8 bytes each, one for
// even and one for odd rows, so any window reads in one access. For a compare-and-
// swap or a write, the accept cycle issues the read, and the execution state that
// follows compares, merges and writes back once the output register is free; no
// new request is accepted until that execution step has finished. A clear
// sweeps all 64 row pairs, one pair a cycle, zeroing only the bytes in use,
// and then answers from the execution state. After reset the block zeroes the
// whole store with the same sweep and accepts no request word until that sweep
// is done; configuration writes are taken at any time. A finished response
// word is held in an output register, and the next request word is accepted
// while it waits.
module masked_cas_lock_store_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mcls_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  mcls_pkg::req_word_t         req_word,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output mcls_pkg::rsp_word_t         rsp_word
);
    import mcls_pkg::*;

    logic [SIZE_W-1:0] cfg_reg, cfg_next;
    logic [SIZE_W-1:0] size_eff;
    ctrl_t             ctrl;
    mem_req_t          mem_req;
    logic [DATA_W-1:0] even_rdata;
    logic [DATA_W-1:0] odd_rdata;

    // The bytes-in-use register; values above the store size act as the store size.
    assign cfg_next = cfg_we ? cfg_wdata : cfg_reg;
    assign size_eff = (cfg_reg > SIZE_W'(LOCK_BYTES)) ? SIZE_W'(LOCK_BYTES) : cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= SIZE_W'(LOCK_BYTES);
        else
            cfg_reg <= cfg_next;
    end

    // The controller sequences the reset sweep, the clear sweep and each request.
    mcls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req_word.operation),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl)
    );

    // The datapath steers both RAM ports and builds the response word.
    mcls_datapath u_datapath (
        .clk        (clk),
        .ctrl       (ctrl),
        .req_word   (req_word),
        .size_eff   (size_eff),
        .even_rdata (even_rdata),
        .odd_rdata  (odd_rdata),
        .mem_req    (mem_req),
        .rsp_word   (rsp_word)
    );

    // Rows 0, 2, 4 and so on.
    mcls_ram #(
        .WIDTH (DATA_W),
        .DEPTH (PAIRS)
    ) u_ram_even (
        .clk   (clk),
        .we    (mem_req.even_we),
        .re    (mem_req.re),
        .addr  (mem_req.even_addr),
        .wdata (mem_req.even_wdata),
        .rdata (even_rdata)
    );

    // Rows 1, 3, 5 and so on.
    mcls_ram #(
        .WIDTH (DATA_W),
        .DEPTH (PAIRS)
    ) u_ram_odd (
        .clk   (clk),
        .we    (mem_req.odd_we),
        .re    (mem_req.re),
        .addr  (mem_req.odd_addr),
        .wdata (mem_req.odd_wdata),
        .rdata (odd_rdata)
    );

endmodule

// ----- sim/tb_masked_cas_lock_store_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for masked_cas_lock_store_top: a shadow lock store predicts every
// response word, and random request traffic runs under several bytes_in_use settings.
// Depends on mcls_pkg and the RTL of masked_cas_lock_store_top.

// Shadow copy of the lock bytes and of bytes_in_use, plus the queue of response words that
// accepted requests still owe.
class lock_store_shadow;
    logic [7:0]                  stored_bytes [mcls_pkg::LOCK_BYTES];
    logic [mcls_pkg::SIZE_W-1:0] bytes_in_use;
    mcls_pkg::rsp_word_t         owed_rsps [$];
    int                          mismatches;

    function new();
        foreach (stored_bytes[i])
        begin
            stored_bytes[i] = 8'h00;
        end
        bytes_in_use = 11'd1024;
        mismatches   = 0;
    endfunction

    // Register values past the store size saturate.
    function int window_limit();
        if (bytes_in_use > mcls_pkg::LOCK_BYTES)
        begin
            return mcls_pkg::LOCK_BYTES;
        end
        return int'(bytes_in_use);
    endfunction

    // Little-endian: the lowest byte address is the least significant byte.
    function logic [63:0] peek_window(int base);
        logic [63:0] w;
        w = '0;
        for (int k = 0; k < mcls_pkg::WORD_BYTES; k++)
        begin
            w[8*k +: 8] = stored_bytes[(base + k) % mcls_pkg::LOCK_BYTES];
        end
        return w;
    endfunction

    function int outstanding();
        return owed_rsps.size();
    endfunction

    function void note_request(mcls_pkg::req_word_t req);
        mcls_pkg::rsp_word_t exp;
        logic [63:0]         cur;
        logic [63:0]         merged;
        int                  limit;
        exp   = '0;
        limit = window_limit();
        case (req.operation)
            mcls_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < limit; i++)
                begin
                    stored_bytes[i] = 8'h00;
                end
                exp.success = 1'b1;
            end
            mcls_pkg::OP_CAS, mcls_pkg::OP_WRITE:
            begin
                if (int'(req.byte_index) + mcls_pkg::WORD_BYTES > limit)
                begin
                    exp.range_error = 1'b1;
                end
                else
                begin
                    cur             = peek_window(int'(req.byte_index));
                    exp.prior_value = cur;
                    if (req.operation == mcls_pkg::OP_WRITE ||
                        ((req.compare_value ^ cur) & req.bit_mask) == 64'd0)
                    begin
                        merged = (cur & ~req.bit_mask) | (req.swap_value & req.bit_mask);
                        for (int k = 0; k < mcls_pkg::WORD_BYTES; k++)
                        begin
                            stored_bytes[int'(req.byte_index) + k] = merged[8*k +: 8];
                        end
                        exp.success = 1'b1;
                    end
                end
            end
            default:
            begin
                // The unused code changes nothing and answers with all fields zero.
            end
        endcase
        owed_rsps.push_back(exp);
    endfunction

    function void check_response(mcls_pkg::rsp_word_t got);
        mcls_pkg::rsp_word_t exp;
        if (owed_rsps.size() == 0)
        begin
            $error("response word with none owed: prior_value %h success %b range_error %b",
                   got.prior_value, got.success, got.range_error);
            mismatches++;
            return;
        end
        exp = owed_rsps.pop_front();
        if (got.prior_value !== exp.prior_value)
        begin
            $error("prior_value: expected %h, got %h", exp.prior_value, got.prior_value);
            mismatches++;
        end
        if (got.success !== exp.success)
        begin
            $error("success: expected %b, got %b", exp.success, got.success);
            mismatches++;
        end
        if (got.range_error !== exp.range_error)
        begin
            $error("range_error: expected %b, got %b", exp.range_error, got.range_error);
            mismatches++;
        end
    endfunction
endclass

module tb_masked_cas_lock_store_top;
    import mcls_pkg::*;

    // Code 3 has no meaning in the block; it must be answered with an all-zero word.
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [63:0] ALL_ONES   = {64{1'b1}};
    // Cycles without any accepted word before the run is declared hung. The slowest legal
    // gap is a clear sweep behind a long response stall and a long sender gap, well below this.
    localparam int          STALL_LIMIT = 2000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [SIZE_W-1:0]    cfg_wdata = '0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_word_t            req_word  = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_word_t            rsp_word;

    lock_store_shadow     shadow;
    int                   hot_base;
    int                   idle_cycles = 0;

    masked_cas_lock_store_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    always #10 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Present one request word at the falling edge and hold it until it is taken. The shadow
    // store is updated at the accepting edge, so the next word can be built from it.
    task automatic send_req(input req_word_t w);
        @(negedge clk);
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        shadow.note_request(w);
    endtask

    task automatic send_fields(input logic [1:0] op, input int idx, input logic [63:0] cmp,
                               input logic [63:0] swp, input logic [63:0] mask);
        req_word_t w;
        w.operation     = op;
        w.byte_index    = idx[IDX_W-1:0];
        w.compare_value = cmp;
        w.swap_value    = swp;
        w.bit_mask      = mask;
        send_req(w);
    endtask

    // Keep the request side quiet for the given number of cycles.
    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Stop sending and wait until every owed response word has come back.
    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (shadow.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_bytes_in_use(input logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow.bytes_in_use = value;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            return 0;
        end
        if (pick < 88)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Build a random request word. Most windows land in a small hot region so that
    // consecutive requests touch the same or overlapping bytes, and most compare values are
    // taken from the current window contents so that compare-and-swap actually succeeds.
    function automatic req_word_t next_request();
        req_word_t   w;
        int          top;
        int          pick;
        int          idx;
        logic [7:0]  lanes;
        logic [63:0] cur;
        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            w.operation = OP_CLEAR;
        end
        else if (pick < 7)
        begin
            w.operation = OP_UNUSED;
        end
        else if (pick < 52)
        begin
            w.operation = OP_CAS;
        end
        else
        begin
            w.operation = OP_WRITE;
        end

        // Highest window start that still fits; negative when no window fits at all.
        top  = shadow.window_limit() - WORD_BYTES;
        pick = $urandom_range(0, 99);
        if (top < 0)
        begin
            idx = $urandom_range(0, LOCK_BYTES - 1);
        end
        else if (pick >= 90)
        begin
            idx = $urandom_range(top + 1, LOCK_BYTES - 1);
        end
        else if (pick < 70)
        begin
            idx = hot_base + $urandom_range(0, 23);
            if (idx > top)
            begin
                idx = top;
            end
        end
        else if (pick < 80)
        begin
            idx = top;
        end
        else
        begin
            idx = $urandom_range(0, top);
        end
        w.byte_index = idx[IDX_W-1:0];

        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            w.bit_mask = ALL_ONES;
        end
        else if (pick < 25)
        begin
            w.bit_mask = '0;
        end
        else if (pick < 40)
        begin
            lanes = 8'($urandom);
            for (int k = 0; k < WORD_BYTES; k++)
            begin
                w.bit_mask[8*k +: 8] = {8{lanes[k]}};
            end
        end
        else if (pick < 50)
        begin
            w.bit_mask = 64'd1 << $urandom_range(0, 63);
        end
        else
        begin
            w.bit_mask = rand64();
        end

        w.swap_value = ($urandom_range(0, 9) == 0) ? ALL_ONES : rand64();

        cur  = shadow.peek_window(idx);
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            w.compare_value = (cur & w.bit_mask) | (rand64() & ~w.bit_mask);
        end
        else if (pick < 80)
        begin
            w.compare_value = cur ^ (64'd1 << $urandom_range(0, 63));
        end
        else
        begin
            w.compare_value = rand64();
        end
        return w;
    endfunction

    // One random phase under the current bytes_in_use; only words the block acts on count.
    task automatic run_phase(input int target);
        req_word_t w;
        int        counted;
        int        burst_left;
        bit        gapless;
        int        top;
        counted    = 0;
        burst_left = 0;
        gapless    = 1'b0;
        top        = shadow.window_limit() - WORD_BYTES;
        hot_base   = (top > 24) ? $urandom_range(0, top - 24) : 0;
        while (counted < target)
        begin
            if (burst_left == 0)
            begin
                gapless    = ($urandom_range(0, 3) == 0);
                burst_left = $urandom_range(10, 60);
            end
            burst_left--;
            if ($urandom_range(0, 199) == 0)
            begin
                drain_results();
            end
            else if (!gapless)
            begin
                hold_off(gap_length());
            end
            w = next_request();
            send_req(w);
            if (w.operation != OP_UNUSED)
            begin
                counted++;
            end
        end
    endtask

    // The response side stalls at random too, with stretches of steady readiness.
    int ready_hold = 0;
    int mode_left  = 0;
    bit ready_solid = 1'b0;

    always @(negedge clk)
    begin
        int pick;
        if (mode_left == 0)
        begin
            ready_solid = ($urandom_range(0, 3) == 0);
            mode_left   = $urandom_range(20, 100);
        end
        mode_left--;
        if (ready_hold > 0)
        begin
            ready_hold--;
            rsp_ready <= 1'b0;
        end
        else if (ready_solid)
        begin
            rsp_ready <= 1'b1;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                rsp_ready <= 1'b1;
            end
            else
            begin
                rsp_ready  <= 1'b0;
                ready_hold = (pick < 92) ? $urandom_range(0, 2) : $urandom_range(9, 39);
            end
        end
    end

    // Every accepted response word is checked against the oldest owed one. The same process
    // keeps the watchdog: any accepted word on either side restarts its count.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            shadow.check_response(rsp_word);
        end
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int phase_sizes [10];
        int target;
        shadow = new();
        phase_sizes = '{8, 2047, 64, 1025, 0, 13, 1024, 0, 200, 1024};
        phase_sizes[7] = $urandom_range(0, 2047);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // The block is still sweeping its store clear here; the register is taken anyway,
        // and the first request word waits for req_ready.
        set_bytes_in_use(11'd1024);

        // Directed words: full and empty masks, match and mismatch, both ends of the store,
        // windows that straddle rows, the unused code, and a clear followed by reads.
        send_fields(OP_WRITE, 0, rand64(), ALL_ONES, ALL_ONES);
        send_fields(OP_CAS, 0, ALL_ONES, 64'h0123_4567_89AB_CDEF, ALL_ONES);
        send_fields(OP_CAS, 0, '0, ALL_ONES, ALL_ONES);
        send_fields(OP_CAS, 0, rand64(), rand64(), '0);
        send_fields(OP_CAS, 3, shadow.peek_window(3) ^ 64'h00FF_00FF_00FF_00FF, rand64(),
                    64'hFF00_FF00_FF00_FF00);
        send_fields(OP_WRITE, 5, rand64(), 64'hA5A5_A5A5_A5A5_A5A5, 64'hF0F0_F0F0_F0F0_F0F0);
        send_fields(OP_WRITE, LOCK_BYTES - WORD_BYTES, rand64(), ALL_ONES, ALL_ONES);
        send_fields(OP_CAS, LOCK_BYTES - WORD_BYTES, ALL_ONES, '0, 64'h8000_0000_0000_0000);
        send_fields(OP_CAS, LOCK_BYTES - WORD_BYTES + 1, ALL_ONES, ALL_ONES, ALL_ONES);
        send_fields(OP_WRITE, LOCK_BYTES - 1, ALL_ONES, ALL_ONES, ALL_ONES);
        send_fields(OP_UNUSED, LOCK_BYTES - 1, ALL_ONES, ALL_ONES, ALL_ONES);
        send_fields(OP_CLEAR, LOCK_BYTES - 1, ALL_ONES, ALL_ONES, ALL_ONES);
        send_fields(OP_CAS, 0, '0, ALL_ONES, ALL_ONES);
        send_fields(OP_CAS, 0, ALL_ONES, '0, ALL_ONES);
        send_fields(OP_CAS, 4, shadow.peek_window(4), rand64(), ALL_ONES);
        send_fields(OP_WRITE, 8, '0, ALL_ONES, 64'h8000_0000_0000_0001);
        send_fields(OP_CAS, LOCK_BYTES - WORD_BYTES, '0, rand64(), ALL_ONES);

        // Smallest useful store: one window fits, the next one up does not.
        drain_results();
        set_bytes_in_use(11'd8);
        send_fields(OP_WRITE, 0, '0, ALL_ONES, ALL_ONES);
        send_fields(OP_CAS, 1, ALL_ONES, '0, ALL_ONES);
        send_fields(OP_CLEAR, 0, '0, '0, '0);
        send_fields(OP_CAS, 0, '0, rand64(), ALL_ONES);

        // Random phases, each under its own register value. Tiny stores get fewer words
        // since most of their traffic ends in a range error.
        foreach (phase_sizes[p])
        begin
            drain_results();
            set_bytes_in_use(phase_sizes[p][SIZE_W-1:0]);
            target = (shadow.window_limit() < 64) ? 60 : 210;
            run_phase(target);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.outstanding() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/mcls_pkg.sv
hw/rtl/mcls_ram.sv
hw/rtl/mcls_ctrl.sv
hw/rtl/mcls_datapath.sv
hw/rtl/masked_cas_lock_store_top.sv
sim/tb_masked_cas_lock_store_top.sv
